@@ design/abkf_pkg.sv @@
// Shared types, register indexes and saturating helpers for the angle/bias Kalman filter.
// No dependencies.
package abkf_pkg;

  localparam int DataW   = 64;
  localparam int FieldW  = 32;
  localparam int RegIdxW = 2;

  localparam logic [RegIdxW-1:0] REG_ANGLE_NOISE  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_BIAS_NOISE   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_MEAS_NOISE   = 2'd2;
  localparam logic [RegIdxW-1:0] REG_SAMPLE_PER   = 2'd3;

  localparam logic [FieldW-1:0] ANGLE_NOISE_RST = 32'd16777;
  localparam logic [FieldW-1:0] BIAS_NOISE_RST  = 32'd50332;
  localparam logic [FieldW-1:0] MEAS_NOISE_RST  = 32'd8388608;
  localparam logic [FieldW-1:0] SAMPLE_PER_RST  = 32'd21474836;

  localparam int DefFracBits = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_ANGLE_PRED,
    OP_P0_PRED,
    OP_P12_PRED,
    OP_P3_PRED,
    OP_K0,
    OP_K1,
    OP_P0_UPD,
    OP_P1_UPD,
    OP_P2_UPD,
    OP_P3_UPD,
    OP_ANGLE_UPD,
    OP_BIAS_UPD
  } op_t;

  function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_add = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sat_add = s[DataW-1:0];
    end
  endfunction

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_sub = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sat_sub = s[DataW-1:0];
    end
  endfunction

  function automatic logic [DataW-1:0] mag(input logic signed [DataW-1:0] a);
    mag = a[DataW-1] ? (DataW'(0) - a) : a;
  endfunction

endpackage

@@ design/abkf_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, floor shift, 64-bit saturation.
// Depends on abkf_pkg.
module abkf_mul #(
  parameter int STATE_FRAC_BITS = abkf_pkg::DefFracBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [abkf_pkg::DataW-1:0]    a,
  input  logic signed [abkf_pkg::DataW-1:0]    b,
  input  logic                                 frac_shift,
  output logic                                 done,
  output logic signed [abkf_pkg::DataW-1:0]    result
);
  import abkf_pkg::*;

  localparam int CntW = $clog2(DataW);
  localparam int PW   = 2 * DataW;

  logic            busy, fin, neg;
  logic [CntW-1:0] cnt;
  logic [DataW-1:0] ma, hi, lo;
  logic [DataW:0]   sum;
  logic signed [PW-1:0] prod, r32, rf, rsel;
  logic signed [DataW-1:0] sat_val;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, ma} : '0);

  always_comb begin
    prod = neg ? (PW'(0) - {hi, lo}) : {hi, lo};
    r32  = prod >>> 32;
    rf   = prod >>> STATE_FRAC_BITS;
    rsel = frac_shift ? rf : r32;
    if (rsel[PW-1:DataW-1] != {(PW-DataW+1){1'b0}} &&
        rsel[PW-1:DataW-1] != {(PW-DataW+1){1'b1}}) begin
      sat_val = prod[PW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sat_val = rsel[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= mag(a);
      lo  <= mag(b);
      hi  <= '0;
      neg <= a[DataW-1] ^ b[DataW-1];
      cnt <= CntW'(DataW - 1);
    end else if (busy) begin
      hi  <= sum[DataW:1];
      lo  <= {sum[0], lo[DataW-1:1]};
      cnt <= cnt - 1'b1;
    end
    if (fin) begin
      result <= sat_val;
    end
  end

endmodule

@@ design/abkf_div.sv @@
// Restoring divider: (n << F) / d, one quotient bit per cycle, truncated and saturated.
// Depends on abkf_pkg.
module abkf_div #(
  parameter int STATE_FRAC_BITS = abkf_pkg::DefFracBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [abkf_pkg::DataW-1:0]    num,
  input  logic signed [abkf_pkg::DataW-1:0]    den,
  output logic                                 done,
  output logic signed [abkf_pkg::DataW-1:0]    result
);
  import abkf_pkg::*;

  localparam int QW   = 2 * DataW;
  localparam int CntW = $clog2(QW);

  logic            busy, fin, neg, zero_d;
  logic [CntW-1:0] cnt;
  logic [DataW-1:0] ud, rem;
  logic [QW-1:0]    dq;
  logic [DataW:0]   rem2, diff;
  logic             qbit;
  logic signed [DataW-1:0] q_val;

  assign rem2 = {rem, dq[QW-1]};
  assign diff = rem2 - {1'b0, ud};
  assign qbit = (rem2 >= {1'b0, ud});

  always_comb begin
    if (zero_d) begin
      q_val = '0;
    end else if (neg) begin
      if (dq[QW-1:DataW] != '0 || dq[DataW-1]) begin
        q_val = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        q_val = DataW'(0) - dq[DataW-1:0];
      end
    end else if (dq[QW-1:DataW] != '0 || dq[DataW-1]) begin
      q_val = {1'b0, {(DataW-1){1'b1}}};
    end else begin
      q_val = dq[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ud     <= mag(den);
      dq     <= {{DataW{1'b0}}, mag(num)} << STATE_FRAC_BITS;
      rem    <= '0;
      neg    <= num[DataW-1] ^ den[DataW-1];
      zero_d <= (den == '0);
      cnt    <= CntW'(QW - 1);
    end else if (busy) begin
      rem <= qbit ? diff[DataW-1:0] : rem2[DataW-1:0];
      dq  <= {dq[QW-2:0], qbit};
      cnt <= cnt - 1'b1;
    end
    if (fin) begin
      result <= q_val;
    end
  end

endmodule

@@ design/angle_bias_kalman_filter.sv @@
// Two-state Kalman filter (angle, gyro bias): sequencer, state registers, config.
// Depends on abkf_pkg, abkf_mul and abkf_div.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid, in_stall, measured_angle,  | in
//           | rotation_rate                        |
//  result   | out_valid, out_stall, angle_estimate,| out
//           | bias_estimate                        |
//  config   | cfg_write, cfg_index, cfg_data       | in
//
// Each request runs ten products on the shared bit-serial multiplier and
// two gains on the restoring divider, one bit per cycle in both, plus
// accept and load.
// Synchronous reset puts the state to zero with identity covariance and loads
// the default noise and period registers.
// in_stall is high from acceptance until the result is in the output register;
// a new request is taken while that result still waits on out_stall.
module angle_bias_kalman_filter #(
  parameter int STATE_FRAC_BITS = abkf_pkg::DefFracBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [abkf_pkg::FieldW-1:0]  measured_angle,
  input  logic signed [abkf_pkg::FieldW-1:0]  rotation_rate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [abkf_pkg::FieldW-1:0]  angle_estimate,
  output logic signed [abkf_pkg::FieldW-1:0]  bias_estimate,
  input  logic                                cfg_write,
  input  logic [abkf_pkg::RegIdxW-1:0]        cfg_index,
  input  logic [abkf_pkg::FieldW-1:0]         cfg_data
);
  import abkf_pkg::*;

  localparam int InShift    = STATE_FRAC_BITS - 16;
  localparam int NoiseShift = STATE_FRAC_BITS - 24;
  localparam logic signed [DataW-1:0] One = DataW'(1) << STATE_FRAC_BITS;

  // configuration
  logic [FieldW-1:0] angle_noise, bias_noise, meas_noise, sample_per;

  // filter state and per-request scratch
  logic signed [DataW-1:0] angle, bias, p0, p1, p2, p3;
  logic signed [DataW-1:0] meas, rate, err, e_den, k0, k1, t0, t1;

  seq_state_t state, state_next;
  op_t        op;

  logic mul_start, div_start, mul_done, div_done;
  logic signed [DataW-1:0] mul_a, mul_b, mul_res, div_n, div_res;
  logic mul_frac, is_div, unit_done, load_out;

  logic signed [DataW-1:0] nq_a, nq_b, nq_m, dt;
  logic signed [DataW-1:0] ang_sh, bias_sh;

  assign nq_a = DataW'({{(DataW-FieldW){1'b0}}, angle_noise} << NoiseShift);
  assign nq_b = DataW'({{(DataW-FieldW){1'b0}}, bias_noise} << NoiseShift);
  assign nq_m = DataW'({{(DataW-FieldW){1'b0}}, meas_noise} << NoiseShift);
  assign dt   = {{(DataW-FieldW){1'b0}}, sample_per};

  // config writes; out-of-range indexes cannot occur with a 2-bit index
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RST;
      bias_noise  <= BIAS_NOISE_RST;
      meas_noise  <= MEAS_NOISE_RST;
      sample_per  <= SAMPLE_PER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ANGLE_NOISE: angle_noise <= cfg_data;
        REG_BIAS_NOISE:  bias_noise  <= cfg_data;
        REG_MEAS_NOISE:  meas_noise  <= cfg_data;
        REG_SAMPLE_PER:  sample_per  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // operand selection for the current micro-op
  always_comb begin
    mul_a    = '0;
    mul_b    = dt;
    mul_frac = 1'b0;
    div_n    = p0;
    is_div   = 1'b0;
    unique case (op)
      OP_ANGLE_PRED: mul_a = sat_sub(rate, bias);
      OP_P0_PRED:    mul_a = sat_sub(sat_sub(nq_a, p1), p2);
      OP_P12_PRED:   mul_a = sat_sub('0, p3);
      OP_P3_PRED:    mul_a = nq_b;
      OP_K0:         is_div = 1'b1;
      OP_K1: begin
        is_div = 1'b1;
        div_n  = p2;
      end
      OP_P0_UPD:    begin mul_a = k0; mul_b = t0;  mul_frac = 1'b1; end
      OP_P1_UPD:    begin mul_a = k0; mul_b = t1;  mul_frac = 1'b1; end
      OP_P2_UPD:    begin mul_a = k1; mul_b = t0;  mul_frac = 1'b1; end
      OP_P3_UPD:    begin mul_a = k1; mul_b = t1;  mul_frac = 1'b1; end
      OP_ANGLE_UPD: begin mul_a = k0; mul_b = err; mul_frac = 1'b1; end
      OP_BIAS_UPD:  begin mul_a = k1; mul_b = err; mul_frac = 1'b1; end
      default: ;
    endcase
  end

  assign unit_done = is_div ? div_done : mul_done;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT:  if (unit_done) state_next = (op == OP_BIAS_UPD) ? ST_DONE : ST_ISSUE;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mul_start = (state == ST_ISSUE) && !is_div;
    div_start = (state == ST_ISSUE) && is_div;
    load_out  = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_ANGLE_PRED;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        op <= OP_ANGLE_PRED;
      end else if (state == ST_WAIT && unit_done && op != OP_BIAS_UPD) begin
        op <= op_t'(op + 1'b1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // filter state writeback
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      p0    <= One;
      p1    <= '0;
      p2    <= '0;
      p3    <= One;
    end else if (state == ST_WAIT && unit_done) begin
      unique case (op)
        OP_ANGLE_PRED: angle <= sat_add(angle, mul_res);
        OP_P0_PRED:    p0 <= sat_add(p0, mul_res);
        OP_P12_PRED: begin
          p1 <= sat_add(p1, mul_res);
          p2 <= sat_add(p2, mul_res);
        end
        OP_P3_PRED:    p3 <= sat_add(p3, mul_res);
        OP_P0_UPD:     p0 <= sat_sub(p0, mul_res);
        OP_P1_UPD:     p1 <= sat_sub(p1, mul_res);
        OP_P2_UPD:     p2 <= sat_sub(p2, mul_res);
        OP_P3_UPD:     p3 <= sat_sub(p3, mul_res);
        OP_ANGLE_UPD:  angle <= sat_add(angle, mul_res);
        OP_BIAS_UPD:   bias <= sat_add(bias, mul_res);
        default: ;
      endcase
    end
  end

  // scratch registers (no reset needed)
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      meas <= DataW'(64'(measured_angle) <<< InShift);
      rate <= DataW'(64'(rotation_rate) <<< InShift);
    end
    if (state == ST_WAIT && unit_done) begin
      unique case (op)
        OP_P3_PRED: begin
          err   <= sat_sub(meas, angle);
          e_den <= sat_add(nq_m, p0);
        end
        OP_K0: k0 <= div_res;
        OP_K1: begin
          k1 <= div_res;
          t0 <= p0;
          t1 <= p1;
        end
        default: ;
      endcase
    end
  end

  // result conversion to Q16.16 with floor shift and saturation
  always_comb begin
    ang_sh  = angle >>> InShift;
    bias_sh = bias >>> InShift;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (ang_sh[DataW-1:FieldW-1] != '0 && ang_sh[DataW-1:FieldW-1] != '1) begin
        angle_estimate <= ang_sh[DataW-1] ? {1'b1, {(FieldW-1){1'b0}}}
                                          : {1'b0, {(FieldW-1){1'b1}}};
      end else begin
        angle_estimate <= ang_sh[FieldW-1:0];
      end
      if (bias_sh[DataW-1:FieldW-1] != '0 && bias_sh[DataW-1:FieldW-1] != '1) begin
        bias_estimate <= bias_sh[DataW-1] ? {1'b1, {(FieldW-1){1'b0}}}
                                          : {1'b0, {(FieldW-1){1'b1}}};
      end else begin
        bias_estimate <= bias_sh[FieldW-1:0];
      end
    end
  end

  abkf_mul #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_mul (
    .clk        (clk),
    .rst        (rst),
    .start      (mul_start),
    .a          (mul_a),
    .b          (mul_b),
    .frac_shift (mul_frac),
    .done       (mul_done),
    .result     (mul_res)
  );

  abkf_div #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_n),
    .den    (e_den),
    .done   (div_done),
    .result (div_res)
  );

endmodule

@@ test/angle_bias_kalman_filter_test.sv @@
// Self-checking bench for the angle/gyro-bias Kalman filter: a scoreboard class holds
// a bit-exact predictor and the queue of awaited estimates; plain tasks drive the block.
// Depends on abkf_pkg and the angle_bias_kalman_filter RTL.
module angle_bias_kalman_filter_test;
  import abkf_pkg::*;

  localparam int FRAC = 40;
  localparam int STALL_LIMIT = 30000;   // cycles with no handshake before giving up
  localparam int LONG_HOLD = 4000;      // receiver hold-off that backs up the filter

  typedef logic signed [63:0] s64_t;
  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  // Scoreboard: own copy of registers and filter state, one expected estimate per request.
  class filter_scoreboard;
    logic [31:0] q_angle, q_bias, r_meas, period;
    s64_t angle_st, bias_st;
    s64_t p[4];
    estimate_t expected_estimates[$];
    int errors;

    function new();
      q_angle = ANGLE_NOISE_RST;
      q_bias = BIAS_NOISE_RST;
      r_meas = MEAS_NOISE_RST;
      period = SAMPLE_PER_RST;
      angle_st = '0;
      bias_st = '0;
      p[0] = s64_t'(1) <<< FRAC;
      p[1] = '0;
      p[2] = '0;
      p[3] = s64_t'(1) <<< FRAC;
      errors = 0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        REG_ANGLE_NOISE: q_angle = val;
        REG_BIAS_NOISE:  q_bias = val;
        REG_MEAS_NOISE:  r_meas = val;
        REG_SAMPLE_PER:  period = val;
        default: ;
      endcase
    endfunction

    function s64_t sadd(s64_t a, s64_t b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
    endfunction

    function s64_t ssub(s64_t a, s64_t b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
    endfunction

    // exact product, floor shift, saturate
    function s64_t mulq(s64_t a, s64_t b, int sh);
      logic signed [127:0] prod;
      prod = a * b;
      prod = prod >>> sh;
      if (prod[127:63] != {65{prod[63]}}) return prod[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return prod[63:0];
    endfunction

    // (n << sh) / d, truncated toward zero; zero divisor gives zero
    function s64_t divq(s64_t n, s64_t d, int sh);
      logic [63:0] un, ud;
      logic [127:0] quo;
      if (d == 0) return '0;
      un = n[63] ? 64'd0 - n : n;
      ud = d[63] ? 64'd0 - d : d;
      quo = ({64'd0, un} << sh) / {64'd0, ud};
      if (n[63] != d[63]) begin
        if (quo > 128'h8000_0000_0000_0000) return {1'b1, 63'd0};
        return 64'd0 - quo[63:0];
      end
      if (quo > 128'h7fff_ffff_ffff_ffff) return {1'b0, {63{1'b1}}};
      return quo[63:0];
    endfunction

    function logic signed [31:0] to_q16(s64_t v);
      s64_t r;
      r = v >>> (FRAC - 16);
      if (r > 64'sh7fff_ffff) return 32'h7fff_ffff;
      if (r < -64'sh8000_0000) return 32'h8000_0000;
      return r[31:0];
    endfunction

    // one predict/correct step of the filter
    function void note_request(logic [31:0] m_in, logic [31:0] r_in);
      s64_t meas, rate, dt, d0, d1, d3, err, e, k0, k1, t0, t1;
      estimate_t est;
      meas = {{32{m_in[31]}}, m_in} <<< (FRAC - 16);
      rate = {{32{r_in[31]}}, r_in} <<< (FRAC - 16);
      dt = {32'd0, period};
      angle_st = sadd(angle_st, mulq(ssub(rate, bias_st), dt, 32));
      d0 = ssub(ssub({32'd0, q_angle} <<< (FRAC - 24), p[1]), p[2]);
      d1 = ssub(0, p[3]);
      d3 = {32'd0, q_bias} <<< (FRAC - 24);
      p[0] = sadd(p[0], mulq(d0, dt, 32));
      p[1] = sadd(p[1], mulq(d1, dt, 32));
      p[2] = sadd(p[2], mulq(d1, dt, 32));
      p[3] = sadd(p[3], mulq(d3, dt, 32));
      err = ssub(meas, angle_st);
      e = sadd({32'd0, r_meas} <<< (FRAC - 24), p[0]);
      k0 = divq(p[0], e, FRAC);
      k1 = divq(p[2], e, FRAC);
      t0 = p[0];
      t1 = p[1];
      p[0] = ssub(p[0], mulq(k0, t0, FRAC));
      p[1] = ssub(p[1], mulq(k0, t1, FRAC));
      p[2] = ssub(p[2], mulq(k1, t0, FRAC));
      p[3] = ssub(p[3], mulq(k1, t1, FRAC));
      angle_st = sadd(angle_st, mulq(k0, err, FRAC));
      bias_st = sadd(bias_st, mulq(k1, err, FRAC));
      est.angle = to_q16(angle_st);
      est.bias = to_q16(bias_st);
      expected_estimates.push_back(est);
    endfunction

    function void check_result(logic [31:0] a, logic [31:0] b);
      estimate_t est;
      if (expected_estimates.size() == 0) begin
        $error("unexpected result: angle_estimate %h bias_estimate %h", a, b);
        errors++;
        return;
      end
      est = expected_estimates.pop_front();
      if (a !== est.angle) begin
        $error("angle_estimate: expected %h actual %h", est.angle, a);
        errors++;
      end
      if (b !== est.bias) begin
        $error("bias_estimate: expected %h actual %h", est.bias, b);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_write;
  logic signed [31:0] measured_angle, rotation_rate, angle_estimate, bias_estimate;
  logic [RegIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;

  filter_scoreboard sb = new();
  bit idle_gaps;          // when clear both sides run flat out
  int hold_cycles;        // pending long hold-off on the result side
  int rx_wait;
  int results_seen;
  int quiet_cycles;

  angle_bias_kalman_filter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .measured_angle(measured_angle), .rotation_rate(rotation_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_estimate(angle_estimate), .bias_estimate(bias_estimate),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register write, only issued while the filter has nothing in flight.
  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offer one request, hold it until taken. in_valid only drops for a gap before the next request or in drain.
  task automatic send_request(logic [31:0] m, logic [31:0] r);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_angle <= m;
    rotation_rate <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(m, r);
  endtask

  // Mostly plausible IMU samples, some full-range noise.
  task automatic send_random();
    logic [31:0] m, r;
    if ($urandom_range(0, 3) != 0) begin
      m = $urandom_range(0, 2 * (90 << 16)) - (90 << 16);
      r = $urandom_range(0, 2 * (500 << 16)) - (500 << 16);
    end else begin
      m = $urandom;
      r = $urandom;
    end
    send_request(m, r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_estimates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic config_phase(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm,
                              logic [31:0] dt, int n);
    drain();
    write_reg(REG_ANGLE_NOISE, qa);
    write_reg(REG_BIAS_NOISE, qb);
    write_reg(REG_MEAS_NOISE, rm);
    write_reg(REG_SAMPLE_PER, dt);
    repeat (n) send_random();
  endtask

  // Result side: short random stalls, plus one long hold-off to back the filter up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
      hold_cycles <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(angle_estimate, bias_estimate);
        results_seen <= results_seen + 1;
        if (results_seen == 150) begin
          hold_cycles <= LONG_HOLD;
          out_stall <= 1'b1;
        end else begin
          rx_wait <= idle_gaps ? $urandom_range(0, 13) : 0;
          out_stall <= idle_gaps && ($urandom_range(0, 1) != 0);
        end
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] dir_m[10] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0,
                               32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                               32'h80000000};
    logic [31:0] dir_r[10] = '{32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000,
                               32'h1, 32'h7fffffff, 32'h80000000, 32'h80000000,
                               32'h7fffffff};
    rst <= 1'b1;
    in_valid <= 1'b0;
    measured_angle <= '0;
    rotation_rate <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_ANGLE_NOISE;
    cfg_data <= '0;
    idle_gaps = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under reset settings, then a few plausible samples
    for (int i = 0; i < 10; i++) send_request(dir_m[i], dir_r[i]);
    for (int i = 0; i < 6; i++) send_request(32'(i * 3000), 32'(-i * 700));

    // all-zero noise and period: first step drives P00 to zero, then the divisor is zero
    config_phase(32'd0, 32'd0, 32'd0, 32'd0, 8);
    idle_gaps = 1'b0;
    config_phase(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 60);
    idle_gaps = 1'b1;
    config_phase(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST, SAMPLE_PER_RST, 300);
    config_phase($urandom, $urandom, $urandom_range(1, 32'hffffffff), $urandom, 150);
    idle_gaps = 1'b0;
    config_phase(32'd0, 32'd0, 32'd1, 32'hffffffff, 150);
    idle_gaps = 1'b1;
    config_phase($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                 $urandom_range(1, 1 << 26), $urandom_range(0, 1 << 28), 500);
    config_phase($urandom, $urandom, $urandom, $urandom, 100);

    drain();
    repeat (1000) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ angle_bias_kalman_filter.f @@
design/abkf_pkg.sv
design/abkf_mul.sv
design/abkf_div.sv
design/angle_bias_kalman_filter.sv
test/angle_bias_kalman_filter_test.sv
